// File: hw/rtl/tt800_pkg.sv
// Shared types and constants of the TT800 word generator.
// Used by the cell, feed, top, checker and testbench; depends on nothing.
`default_nettype none

package tt800_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t SEED_MULT    = 32'd1812433253;
    localparam word_t TWIST_VECTOR = 32'h8ebfd028;
    localparam int    SEED_SHIFT   = 30;

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    typedef enum logic [1:0] {
        FEED_ROTATE,
        FEED_SEED,
        FEED_TWIST
    } feed_op_t;

    typedef struct packed {
        feed_op_t op;
        logic     first;
    } feed_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/tt800_cell.sv
// One cell of the state ring: a single 32-bit state word.
// Takes shift_in whenever shift_en is set; uses tt800_pkg.
`default_nettype none

module tt800_cell (
    input  wire logic           clk,
    input  wire logic           shift_en,
    input  wire tt800_pkg::word_t shift_in,
    output tt800_pkg::word_t    word
);

    tt800_pkg::word_t word_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= shift_in;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tt800_feed.sv
// Tail feed of the state ring: seed recurrence, twist, or plain rotate.
// Uses tt800_pkg; drives the word entering the last cell.
`default_nettype none

module tt800_feed #(
    parameter int CNT_W = 5
) (
    input  wire tt800_pkg::feed_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]      step,
    input  wire tt800_pkg::word_t      seed_value,
    input  wire tt800_pkg::word_t      head_word,
    input  wire tt800_pkg::word_t      tap_word,
    input  wire tt800_pkg::word_t      tail_word,
    output tt800_pkg::word_t           feed_word
);

    tt800_pkg::word_t mixed;
    tt800_pkg::word_t seed_word;
    tt800_pkg::word_t twist_word;

    assign mixed      = tail_word ^ (tail_word >> tt800_pkg::SEED_SHIFT);
    assign seed_word  = tt800_pkg::word_t'(tt800_pkg::SEED_MULT * mixed)
                      + {{(tt800_pkg::WORD_W-CNT_W){1'b0}}, step};
    assign twist_word = tap_word ^ (head_word >> 1)
                      ^ (head_word[0] ? tt800_pkg::TWIST_VECTOR : '0);

    always_comb
    begin
        case (ctrl.op)
            tt800_pkg::FEED_SEED:  feed_word = ctrl.first ? seed_value : seed_word;
            tt800_pkg::FEED_TWIST: feed_word = twist_word;
            default:               feed_word = head_word;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tt800_random_word_generator_top.sv
// TT800 twisted GFSR word generator: ring of state cells plus sequencer.
// Depends on tt800_pkg, tt800_cell and tt800_feed.
//
// Command channel (cmd_valid, cmd_stall, mode, seed_value): mode 0 seeds,
// mode 1 draws one word. Word channel (word_valid, word_stall, random_word)
// returns one raw state word per draw; a seed returns nothing.
// The state sits in a ring of STATE_WORDS cells that shifts one word a cycle
// while shift_en is set. A seed loads its value into the ring at acceptance,
// then holds cmd_stall while the recurrence fills the rest, one multiply-add
// per cycle. A draw goes from idle to ST_DRAW, where it waits for a free
// output register and then loads its word into it. The first draw after a
// seed and every STATE_WORDS-th draw after that first run the twist, one
// word a cycle around the ring, in ST_TWIST before reaching ST_DRAW. The
// block handles one command at a time. The finished word sits in an output
// register, so a new command is taken while the previous word waits; a draw
// then holds in its final step until word_stall drops. Reset clears the
// sequencer and the output valid and puts a twist pending; the state words
// stay undefined until the first seed, which must come before any draw.
`default_nettype none

module tt800_random_word_generator_top #(
    parameter int STATE_WORDS = 25,
    parameter int TAP_OFFSET  = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire logic             mode,
    input  wire tt800_pkg::word_t seed_value,
    output logic                  word_valid,
    input  wire logic             word_stall,
    output tt800_pkg::word_t      random_word
);

    localparam int CNT_W   = $clog2(STATE_WORDS);
    localparam int IDX_W   = $clog2(STATE_WORDS + 1);
    localparam int TAP_POS = TAP_OFFSET % STATE_WORDS;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(STATE_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_TWIST,
        ST_DRAW
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [IDX_W-1:0]      read_index_reg, read_index_next;
    logic                  word_valid_reg, word_valid_next;
    tt800_pkg::word_t      random_word_reg, random_word_next;

    logic                  cmd_acc;
    logic                  out_free;
    logic                  shift_en;
    tt800_pkg::feed_ctrl_t feed_ctrl;
    tt800_pkg::word_t      feed_word;
    tt800_pkg::word_t      cell_word [STATE_WORDS];

    genvar k;
    generate
        for (k = 0; k < STATE_WORDS; k++)
        begin : g_ring
            if (k == STATE_WORDS - 1)
            begin : g_tail
                tt800_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .shift_in (feed_word),
                    .word     (cell_word[k])
                );
            end
            else
            begin : g_body
                tt800_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .shift_in (cell_word[k+1]),
                    .word     (cell_word[k])
                );
            end
        end
    endgenerate

    tt800_feed #(
        .CNT_W (CNT_W)
    ) u_feed (
        .ctrl       (feed_ctrl),
        .step       (step_reg),
        .seed_value (seed_value),
        .head_word  (cell_word[0]),
        .tap_word   (cell_word[TAP_POS]),
        .tail_word  (cell_word[STATE_WORDS-1]),
        .feed_word  (feed_word)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !word_valid_reg || !word_stall;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        read_index_next  = read_index_reg;
        word_valid_next  = word_valid_reg && word_stall;
        random_word_next = random_word_reg;
        shift_en         = 1'b0;
        feed_ctrl.op     = tt800_pkg::FEED_ROTATE;
        feed_ctrl.first  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    step_next = '0;
                    if (mode == tt800_pkg::MODE_SEED)
                    begin
                        shift_en        = 1'b1;
                        feed_ctrl.op    = tt800_pkg::FEED_SEED;
                        feed_ctrl.first = 1'b1;
                        step_next       = CNT_W'(1);
                        state_next      = ST_SEED;
                    end
                    else if (read_index_reg == IDX_FULL)
                    begin
                        state_next = ST_TWIST;
                    end
                    else
                    begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_SEED:
            begin
                shift_en        = 1'b1;
                feed_ctrl.op    = tt800_pkg::FEED_SEED;
                step_next       = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    read_index_next = IDX_FULL;
                    state_next      = ST_IDLE;
                end
            end
            ST_TWIST:
            begin
                shift_en     = 1'b1;
                feed_ctrl.op = tt800_pkg::FEED_TWIST;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    read_index_next = '0;
                    state_next      = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (out_free)
                begin
                    shift_en         = 1'b1;
                    random_word_next = cell_word[0];
                    word_valid_next  = 1'b1;
                    read_index_next  = read_index_reg + 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            read_index_reg <= IDX_FULL;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            read_index_reg <= read_index_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        random_word_reg <= random_word_next;
    end

    assign word_valid  = word_valid_reg;
    assign random_word = random_word_reg;

    a_word_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(word_valid_reg) |-> $past(state_reg == ST_DRAW))
        else $error("word valid raised outside the draw step");

    a_twist_resets_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TWIST && step_reg == LAST_STEP) |=> read_index_reg == '0)
        else $error("read index not cleared after twist");

    a_seed_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED && step_reg == LAST_STEP) |=>
            (read_index_reg == IDX_FULL && state_reg == ST_IDLE))
        else $error("seed did not leave a twist pending");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        read_index_reg <= IDX_FULL)
        else $error("read index beyond word count");

    a_draw_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid_reg && word_stall) |=> (word_valid_reg && $stable(random_word_reg)))
        else $error("waiting word overwritten");

endmodule

`default_nettype wire

// File: tb/tt800_tb_pkg.sv
// Command codes shared by the word generator testbench files.
// Depends on nothing; used by tt800_word_checker and testbench.
`timescale 1ns / 1ps

package tt800_tb_pkg;

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

endpackage

// File: tb/tt800_word_checker.sv
// Checker for the TT800 word generator: watches both channels, predicts each drawn word
// from its own copy of the state ring and compares. Depends on tt800_pkg and tt800_tb_pkg.
`timescale 1ns / 1ps

module tt800_word_checker #(
    parameter int STATE_WORDS = 25,
    parameter int TAP_OFFSET  = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic             cmd_stall,
    input  wire logic             mode,
    input  wire tt800_pkg::word_t seed_value,
    input  wire logic             word_valid,
    input  wire logic             word_stall,
    input  wire tt800_pkg::word_t random_word,
    output int                    outstanding,
    output int                    failures
);

    tt800_pkg::word_t ring [STATE_WORDS];
    int unsigned      read_pos = STATE_WORDS;
    tt800_pkg::word_t drawn_words [$];

    initial
    begin
        outstanding = 0;
        failures    = 0;
    end

    task automatic load_seed(input tt800_pkg::word_t s);
        tt800_pkg::word_t prev;
        ring[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev    = ring[i-1];
            ring[i] = tt800_pkg::SEED_MULT * (prev ^ (prev >> tt800_pkg::SEED_SHIFT))
                      + tt800_pkg::word_t'(i);
        end
        read_pos = STATE_WORDS;
    endtask

    task automatic twist_ring();
        tt800_pkg::word_t cur;
        for (int kk = 0; kk < STATE_WORDS; kk++)
        begin
            cur      = ring[kk];
            ring[kk] = ring[(kk + TAP_OFFSET) % STATE_WORDS] ^ (cur >> 1)
                       ^ (cur[0] ? tt800_pkg::TWIST_VECTOR : tt800_pkg::word_t'(0));
        end
        read_pos = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tt800_pkg::word_t want;
        if (!rst_n)
        begin
            read_pos = STATE_WORDS;
            drawn_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                if (drawn_words.size() == 0)
                begin
                    $error("random_word: no draw pending, expected none, actual %h",
                           random_word);
                    failures++;
                end
                else
                begin
                    want = drawn_words.pop_front();
                    if (random_word !== want)
                    begin
                        $error("random_word mismatch: expected %h, actual %h",
                               want, random_word);
                        failures++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (mode == tt800_tb_pkg::MODE_SEED)
                    load_seed(seed_value);
                else
                begin
                    if (read_pos >= STATE_WORDS)
                        twist_ring();
                    drawn_words.push_back(ring[read_pos]);
                    read_pos++;
                end
            end
            outstanding <= drawn_words.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the TT800 word generator testbench: clock, reset, seed and draw stimulus,
// random word stalls, verdict. Depends on the DUT, checker and both packages.
`timescale 1ns / 1ps

module testbench;

    localparam int STATE_WORDS = 25;
    localparam int TAP_OFFSET  = 7;
    localparam int ITEM_COUNT  = 1350;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cmd_valid  = 1'b0;
    logic             cmd_stall;
    logic             mode       = tt800_tb_pkg::MODE_SEED;
    tt800_pkg::word_t seed_value = '0;
    logic             word_valid;
    logic             word_stall = 1'b0;
    tt800_pkg::word_t random_word;

    int          outstanding;
    int          failures;
    int unsigned items_sent = 0;
    bit          cmd_quiet  = 1'b0;
    bit          word_quiet = 1'b0;
    int unsigned stall_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tt800_random_word_generator_top #(
        .STATE_WORDS(STATE_WORDS),
        .TAP_OFFSET (TAP_OFFSET)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .mode       (mode),
        .seed_value (seed_value),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .random_word(random_word)
    );

    tt800_word_checker #(
        .STATE_WORDS(STATE_WORDS),
        .TAP_OFFSET (TAP_OFFSET)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .mode       (mode),
        .seed_value (seed_value),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .random_word(random_word),
        .outstanding(outstanding),
        .failures   (failures)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                if ($urandom_range(0, 49) == 0)
                    word_quiet = !word_quiet;
                stall_left = word_quiet ? 0 : $urandom_range(0, 6);
            end
            else if (stall_left != 0)
                stall_left--;
            word_stall <= (stall_left != 0);
        end
    end

    task automatic send_command(input logic m, input tt800_pkg::word_t s);
        int unsigned gap;
        gap = cmd_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        mode       <= m;
        seed_value <= s;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        int unsigned      draws;
        tt800_pkg::word_t s;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(tt800_tb_pkg::MODE_SEED, 32'h0000_0000);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'hFFFF_FFFF);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'h0000_0000);
        send_command(tt800_tb_pkg::MODE_SEED, 32'hFFFF_FFFF);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'hFFFF_FFFF);
        send_command(tt800_tb_pkg::MODE_SEED, 32'h0000_0001);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'h5555_5555);
        send_command(tt800_tb_pkg::MODE_SEED, 32'h8000_0000);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'hAAAA_AAAA);
        send_command(tt800_tb_pkg::MODE_SEED, 32'h7FFF_FFFF);
        send_command(tt800_tb_pkg::MODE_DRAW, 32'h0000_0000);
        send_command(tt800_tb_pkg::MODE_SEED, 32'hA5A5_A5A5);
        repeat (13) send_command(tt800_tb_pkg::MODE_DRAW, 32'hFFFF_FFFF);

        while (items_sent < ITEM_COUNT)
        begin
            cmd_quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 7))
                0:       s = '0;
                1:       s = '1;
                default: s = $urandom();
            endcase
            send_command(tt800_tb_pkg::MODE_SEED, s);
            draws = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 80);
            while (draws != 0 && items_sent < ITEM_COUNT)
            begin
                send_command(tt800_tb_pkg::MODE_DRAW, $urandom());
                draws--;
            end
        end
        cmd_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4 * STATE_WORDS) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
